// ===== src/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types for the JSON string unescaper: request payloads, result
// status codes and the command that passes from the decoder to the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  typedef enum logic [2:0] {
    ST_DATA        = 3'd0,
    ST_DONE        = 3'd1,
    ST_UNTERM_STR  = 3'd2,
    ST_UNTERM_ESC  = 3'd3,
    ST_TRUNC_HEX   = 3'd4,
    ST_BAD_HEX     = 3'd5,
    ST_UNKNOWN_ESC = 3'd6
  } status_e;

  localparam int unsigned MaxBytes = 6;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_ends;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_e    status;
    logic       last;
  } out_t;

  // All results caused by one input request. Only the final result may carry
  // a non-data status; its byte is then zero.
  typedef struct packed {
    logic [2:0]                cnt;
    logic [MaxBytes-1:0][7:0]  bytes;
    status_e                   fin_status;
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front
// Decoder: takes one byte per request, tracks escape / hex / surrogate state
// and builds the full result list of that request as one command.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          take_i,
  input  wire jsu_pkg::in_t  in_i,
  output jsu_pkg::cmd_t      cmd_o,
  output logic               cmd_valid_o
);

  typedef enum logic [2:0] {
    M_PLAIN, M_ESC, M_HEX, M_HELD, M_HELD_BS, M_HEX2
  } mode_e;

  typedef struct packed {
    logic [2:0]       cnt;
    logic [3:0][7:0]  b;
  } enc_t;

  function automatic enc_t utf8_enc(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.cnt  = 3'd1;
      e.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      e.cnt  = 3'd2;
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      e.cnt  = 3'd3;
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
    end else begin
      e.cnt  = 3'd4;
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

  mode_e       mode_q, mode_d;
  logic [1:0]  slot_q, slot_d;
  logic [15:0] acc_q, acc_d;
  logic        bad_q, bad_d;
  logic [9:0]  held_q, held_d;

  logic [7:0]  b;
  logic        ends;
  logic [3:0]  nib;
  logic        is_hex;
  logic [15:0] acc_new;
  logic        bad_new;
  logic        fourth;
  logic        esc_known;
  logic [7:0]  esc_char;

  logic             use_held;
  logic             enc_en;
  logic [20:0]      enc_cp;
  logic [2:0]       m_cnt;
  logic [3:0][7:0]  m_bytes;
  jsu_pkg::status_e fin;
  enc_t             held_enc, main_enc;

  assign b    = in_i.in_byte;
  assign ends = in_i.text_ends;

  always_comb begin
    is_hex = 1'b1;
    nib    = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      nib = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      nib = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      nib = 4'(b - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign acc_new = {acc_q[11:0], nib};
  assign bad_new = bad_q | ~is_hex;
  assign fourth  = (slot_q == 2'd3);

  // Simple escapes; 'u' is handled by the mode logic.
  always_comb begin
    esc_known = 1'b1;
    case (b)
      8'h22:   esc_char = 8'h22;
      8'h5C:   esc_char = 8'h5C;
      8'h2F:   esc_char = 8'h2F;
      8'h62:   esc_char = 8'h08;
      8'h66:   esc_char = 8'h0C;
      8'h6E:   esc_char = 8'h0A;
      8'h72:   esc_char = 8'h0D;
      8'h74:   esc_char = 8'h09;
      default: begin
        esc_char  = 8'h00;
        esc_known = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    slot_d   = slot_q;
    acc_d    = acc_q;
    bad_d    = bad_q;
    held_d   = held_q;
    use_held = 1'b0;
    enc_en   = 1'b0;
    enc_cp   = 21'd0;
    m_cnt    = 3'd0;
    m_bytes  = '0;
    fin      = jsu_pkg::ST_DATA;

    case (mode_q)
      M_ESC, M_HELD_BS: begin
        use_held = (mode_q == M_HELD_BS);
        mode_d   = M_PLAIN;
        if (ends) begin
          m_cnt = 3'd1;
          fin   = jsu_pkg::ST_UNTERM_ESC;
        end else if (b == 8'h75) begin
          use_held = 1'b0;
          mode_d   = (mode_q == M_ESC) ? M_HEX : M_HEX2;
          slot_d   = 2'd0;
          acc_d    = 16'd0;
          bad_d    = 1'b0;
        end else if (esc_known) begin
          m_cnt      = 3'd1;
          m_bytes[0] = esc_char;
        end else begin
          m_cnt = 3'd1;
          fin   = jsu_pkg::ST_UNKNOWN_ESC;
        end
      end
      M_HEX, M_HEX2: begin
        if (ends) begin
          use_held = (mode_q == M_HEX2);
          m_cnt    = 3'd1;
          fin      = jsu_pkg::ST_TRUNC_HEX;
          mode_d   = M_PLAIN;
        end else begin
          acc_d  = acc_new;
          bad_d  = bad_new;
          slot_d = slot_q + 2'd1;
          if (fourth) begin
            if (bad_new) begin
              use_held = (mode_q == M_HEX2);
              m_cnt    = 3'd1;
              fin      = jsu_pkg::ST_BAD_HEX;
              mode_d   = M_PLAIN;
            end else if (mode_q == M_HEX2 && acc_new >= 16'hDC00 && acc_new <= 16'hDFFF) begin
              // surrogate pair joined into one supplementary code point
              enc_en = 1'b1;
              enc_cp = 21'h10000 + {1'b0, held_q, acc_new[9:0]};
              mode_d = M_PLAIN;
            end else begin
              use_held = (mode_q == M_HEX2);
              if (acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
                held_d = acc_new[9:0];
                mode_d = M_HELD;
              end else begin
                enc_en = 1'b1;
                enc_cp = {5'd0, acc_new};
                mode_d = M_PLAIN;
              end
            end
          end
        end
      end
      default: begin
        // plain body, or plain with a high surrogate waiting
        use_held = (mode_q == M_HELD);
        mode_d   = M_PLAIN;
        if (ends) begin
          m_cnt = 3'd1;
          fin   = jsu_pkg::ST_UNTERM_STR;
        end else if (b == 8'h5C) begin
          if (mode_q == M_HELD) begin
            use_held = 1'b0;
            mode_d   = M_HELD_BS;
          end else begin
            mode_d = M_ESC;
          end
        end else if (b == 8'h22) begin
          m_cnt = 3'd1;
          fin   = jsu_pkg::ST_DONE;
        end else begin
          m_cnt      = 3'd1;
          m_bytes[0] = b;
        end
      end
    endcase
  end

  assign held_enc = utf8_enc({5'd0, 6'b110110, held_q});
  assign main_enc = enc_en ? utf8_enc(enc_cp) : enc_t'{cnt: m_cnt, b: m_bytes};

  always_comb begin
    cmd_o            = '0;
    cmd_o.fin_status = fin;
    if (use_held) begin
      cmd_o.cnt      = 3'd3 + main_enc.cnt;
      cmd_o.bytes[0] = held_enc.b[0];
      cmd_o.bytes[1] = held_enc.b[1];
      cmd_o.bytes[2] = held_enc.b[2];
      cmd_o.bytes[3] = main_enc.b[0];
      cmd_o.bytes[4] = main_enc.b[1];
      cmd_o.bytes[5] = main_enc.b[2];
    end else begin
      cmd_o.cnt      = main_enc.cnt;
      cmd_o.bytes[0] = main_enc.b[0];
      cmd_o.bytes[1] = main_enc.b[1];
      cmd_o.bytes[2] = main_enc.b[2];
      cmd_o.bytes[3] = main_enc.b[3];
    end
  end

  assign cmd_valid_o = take_i && (cmd_o.cnt != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_PLAIN;
      slot_q <= 2'd0;
      acc_q  <= 16'd0;
      bad_q  <= 1'b0;
      held_q <= 10'd0;
    end else if (take_i) begin
      mode_q <= mode_d;
      slot_q <= slot_d;
      acc_q  <= acc_d;
      bad_q  <= bad_d;
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/jsu_queue.sv =====
// ----------------------------------------------------------------------------
// jsu_queue
// Two-entry command queue between decoder and serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire jsu_pkg::cmd_t  push_cmd_i,
  output logic                full_o,
  output logic                head_valid_o,
  output jsu_pkg::cmd_t       head_cmd_o,
  input  wire logic           pop_i
);

  jsu_pkg::cmd_t mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    count_q;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back
// Serializer: one head-command result per unstalled cycle; marks the last.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           head_valid_i,
  input  wire jsu_pkg::cmd_t  head_cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output jsu_pkg::out_t       out_o
);

  logic [2:0] idx_q;
  logic       is_last;
  logic       fire;

  assign is_last     = (idx_q == head_cmd_i.cnt - 3'd1);
  assign out_valid_o = head_valid_i;
  assign fire        = head_valid_i && !out_stall_i;
  assign pop_o       = fire && is_last;

  always_comb begin
    out_o.out_byte = head_cmd_i.bytes[idx_q];
    out_o.status   = is_last ? head_cmd_i.fin_status : jsu_pkg::ST_DATA;
    out_o.last     = is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
    end else if (fire) begin
      idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
    end
  end

endmodule

`default_nettype wire

// ===== src/json_string_unescape_utf8_unit.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit
// JSON string body unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
// Input channel: one request per byte of the string body (after the opening
// quote), or a request with text_ends set when the text runs out.
// Output channel: one request per result: a decoded UTF-8 byte (status data)
// or a status (done or an error) with a zero byte; last marks the final
// result caused by an input request. A request may cause zero to six results.
// Throughput: one input request per cycle while each causes at most one
// result and the receiver does not stall; a request with N results holds the
// output until its last result is taken, and the two-entry command queue lets
// the decoder run one request ahead. The decoder holds all escape/surrogate
// state and retires one request per cycle while the queue has room; the
// serializer drains one result per cycle unless the receiver stalls.
// Reset: asynchronous, active low; plain body mode, queue empty.
// When the receiver stalls, the head result holds; the input stalls only when
// both queue entries are in use.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire jsu_pkg::in_t  in_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output jsu_pkg::out_t      out_o
);

  logic          take;
  logic          push;
  jsu_pkg::cmd_t push_cmd;
  logic          full;
  logic          head_valid;
  jsu_pkg::cmd_t head_cmd;
  logic          pop;

  // input accepted whenever the queue has room
  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .in_i        (in_i),
    .cmd_o       (push_cmd),
    .cmd_valid_o (push)
  );

  jsu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd),
    .pop_i        (pop)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

// ===== tb/unescape_check_pkg.sv =====
// ----------------------------------------------------------------------------
// unescape_check_pkg
// Prediction and result checking for the JSON string unescaper: a tracker that
// decodes each accepted request and compares the results that come out.
// ----------------------------------------------------------------------------
package unescape_check_pkg;

  import jsu_pkg::*;

  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharLetterU   = 8'h75;

  localparam int unsigned ReportLimit = 10;

  typedef enum logic [2:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_HEX,
    MODE_HELD,
    MODE_HELD_BS,
    MODE_HEX2
  } decode_mode_e;

  class unescape_tracker;
    decode_mode_e mode;
    logic [1:0]   slot_count;
    logic [15:0]  hex_acc;
    logic         bad_digit;
    logic [9:0]   held_hi;
    out_t         step_results[$];
    out_t         due_results[$];
    int unsigned  mismatches;

    function new();
      mode       = MODE_PLAIN;
      slot_count = '0;
      hex_acc    = '0;
      bad_digit  = 1'b0;
      held_hi    = '0;
      mismatches = 0;
    endfunction

    function void put(logic [7:0] b, status_e st);
      out_t r;
      if (step_results.size() >= MaxBytes) return;
      r.out_byte = b;
      r.status   = st;
      r.last     = 1'b0;
      step_results.insert(step_results.size(), r);
    endfunction

    function void fail_with(status_e st);
      put(8'h00, st);
      mode = MODE_PLAIN;
    endfunction

    function void emit_code_point(logic [20:0] cp);
      if (cp < 21'h80) begin
        put(cp[7:0], ST_DATA);
      end else if (cp < 21'h800) begin
        put({3'b110, cp[10:6]}, ST_DATA);
        put({2'b10, cp[5:0]}, ST_DATA);
      end else if (cp < 21'h10000) begin
        put({4'b1110, cp[15:12]}, ST_DATA);
        put({2'b10, cp[11:6]}, ST_DATA);
        put({2'b10, cp[5:0]}, ST_DATA);
      end else begin
        put({5'b11110, cp[20:18]}, ST_DATA);
        put({2'b10, cp[17:12]}, ST_DATA);
        put({2'b10, cp[11:6]}, ST_DATA);
        put({2'b10, cp[5:0]}, ST_DATA);
      end
    endfunction

    // held_hi is the offset from 0xD800
    function void emit_held();
      emit_code_point({5'b0, 6'b110110, held_hi});
    endfunction

    function void open_hex(decode_mode_e m);
      mode       = m;
      slot_count = '0;
      hex_acc    = '0;
      bad_digit  = 1'b0;
    endfunction

    function void finish_value(logic [15:0] v);
      if (v >= 16'hD800 && v <= 16'hDBFF) begin
        held_hi = v[9:0];
        mode    = MODE_HELD;
      end else begin
        emit_code_point({5'b0, v});
        mode = MODE_PLAIN;
      end
    endfunction

    function void plain_byte(logic [7:0] b);
      mode = MODE_PLAIN;
      if (b == CharQuote) begin
        put(8'h00, ST_DONE);
      end else if (b == CharBackslash) begin
        mode = MODE_ESC;
      end else begin
        put(b, ST_DATA);
      end
    endfunction

    function void escape_byte(logic [7:0] b);
      logic [7:0] c;
      mode = MODE_PLAIN;
      case (b)
        CharQuote, CharBackslash, 8'h2F: c = b;  // " \ /
        8'h62: c = 8'h08;                        // b
        8'h66: c = 8'h0C;                        // f
        8'h6E: c = 8'h0A;                        // n
        8'h72: c = 8'h0D;                        // r
        8'h74: c = 8'h09;                        // t
        CharLetterU: begin
          open_hex(MODE_HEX);
          return;
        end
        default: begin
          fail_with(ST_UNKNOWN_ESC);
          return;
        end
      endcase
      put(c, ST_DATA);
    endfunction

    // any byte fills a slot; non-hex ones only raise the flag
    function logic take_slot(logic [7:0] b);
      logic [3:0] v;
      v = 4'h0;
      if (b >= 8'h30 && b <= 8'h39) begin
        v = b[3:0];
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
        v = b[3:0] + 4'd9;
      end else begin
        bad_digit = 1'b1;
      end
      hex_acc = {hex_acc[11:0], v};
      if (slot_count == 2'd3) begin
        slot_count = '0;
        return 1'b1;
      end
      slot_count = slot_count + 2'd1;
      return 1'b0;
    endfunction

    function void note_request(in_t req);
      logic [7:0]  b;
      logic        ends;
      logic [15:0] v;
      out_t        r;
      b    = req.in_byte;
      ends = req.text_ends;
      step_results.delete();
      case (mode)
        MODE_ESC: begin
          if (ends) fail_with(ST_UNTERM_ESC);
          else escape_byte(b);
        end
        MODE_HEX: begin
          if (ends) begin
            fail_with(ST_TRUNC_HEX);
          end else if (take_slot(b)) begin
            if (bad_digit) fail_with(ST_BAD_HEX);
            else finish_value(hex_acc);
          end
        end
        MODE_HELD: begin
          if (ends) begin
            emit_held();
            fail_with(ST_UNTERM_STR);
          end else if (b == CharBackslash) begin
            mode = MODE_HELD_BS;
          end else begin
            emit_held();
            plain_byte(b);
          end
        end
        MODE_HELD_BS: begin
          if (ends) begin
            emit_held();
            fail_with(ST_UNTERM_ESC);
          end else if (b == CharLetterU) begin
            open_hex(MODE_HEX2);
          end else begin
            emit_held();
            escape_byte(b);
          end
        end
        MODE_HEX2: begin
          if (ends) begin
            emit_held();
            fail_with(ST_TRUNC_HEX);
          end else if (take_slot(b)) begin
            v = hex_acc;
            if (bad_digit) begin
              emit_held();
              fail_with(ST_BAD_HEX);
            end else if (v >= 16'hDC00 && v <= 16'hDFFF) begin
              emit_code_point(21'h10000 + {1'b0, held_hi, v[9:0]});
              mode = MODE_PLAIN;
            end else begin
              emit_held();
              finish_value(v);
            end
          end
        end
        default: begin
          if (ends) fail_with(ST_UNTERM_STR);
          else plain_byte(b);
        end
      endcase
      foreach (step_results[i]) begin
        r      = step_results[i];
        r.last = (i == step_results.size() - 1);
        due_results.insert(due_results.size(), r);
      end
    endfunction

    function void note_mismatch(string what, out_t want, out_t got);
      mismatches++;
      if (mismatches <= ReportLimit) begin
        $display("ERROR %s: expected byte %02h status %0d last %0b", what,
                 want.out_byte, want.status, want.last);
        $display("      got byte %02h status %0d last %0b",
                 got.out_byte, got.status, got.last);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (due_results.size() == 0) begin
        note_mismatch("result with nothing pending", '0, got);
        return;
      end
      want = due_results.pop_front();
      if (got.out_byte !== want.out_byte || got.status !== want.status ||
          got.last !== want.last) begin
        note_mismatch("result differs", want, got);
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for json_string_unescape_utf8_unit. A short directed string and
// then random string bodies (plain bytes, escapes, \u values, surrogate pairs,
// bad and cut-off escapes, text ends) are fed in; every result is checked
// against a predicted UTF-8 byte or status, in order, with random idling and
// stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  import jsu_pkg::*;
  import unescape_check_pkg::*;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned HoldCycles    = 40;
  localparam int unsigned DrainCycles   = 4;
  localparam int unsigned ItemsPerPhase = 100;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_req    = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_res;

  unescape_tracker tracker;

  // idle rates in percent per cycle, set by the main sequence per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // long receiver hold-offs: asked by the main sequence, served by the receiver
  int unsigned hold_asks     = 0;
  int unsigned holds_served  = 0;
  int unsigned sent          = 0;
  int unsigned cycles        = 0;

  json_string_unescape_utf8_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_res)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Both channels are sampled at the rising edge, before the block updates.
  // A result never comes out in the cycle its request is taken, so noting the
  // request first is safe.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.note_request(in_req);
      if (out_valid && !out_stall) tracker.check_result(out_res);
    end
  end

  // Receiver: random stall at the rate of the phase, or a long hold-off that
  // lets the block fill up and push back on the sender.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (holds_served < hold_asks) begin
        holds_served++;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offers one request; called and returns at a falling edge. Valid stays
  // high from one request to the next unless an idle cycle is drawn.
  task automatic send_req(input logic [7:0] b, input logic ends);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{in_byte: b, text_ends: ends};
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_req(b, 1'b0);
  endtask

  // text end carries no byte; the byte lines are random anyway
  task automatic send_end();
    send_req(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  // Sender stops and waits for every pending result, plus a few cycles.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (tracker.due_results.size() != 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  // hex digit with random letter case
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return ($urandom_range(1) ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (is_hex(b));
    return b;
  endfunction

  function automatic logic is_escape_letter(input logic [7:0] b);
    case (b)
      CharQuote, CharBackslash, CharLetterU,
      8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] simple_escape_letter();
    case ($urandom_range(7))
      0: return CharQuote;
      1: return CharBackslash;
      2: return 8'h2F;  // /
      3: return 8'h62;  // b
      4: return 8'h66;  // f
      5: return 8'h6E;  // n
      6: return 8'h72;  // r
      default: return 8'h74;  // t
    endcase
  endfunction

  // value in [lo, hi] with its ends drawn often
  function automatic logic [15:0] span(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(7))
      0: return 16'(lo);
      1: return 16'(hi);
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  // \u value: one to three UTF-8 bytes, lone low or a high that gets held
  function automatic logic [15:0] u_value();
    case ($urandom_range(5))
      0: return span('h0000, 'h007F);
      1: return span('h0080, 'h07FF);
      2: return span('h0800, 'hD7FF);
      3: return span('hE000, 'hFFFF);
      4: return span('hDC00, 'hDFFF);
      default: return span('hD800, 'hDBFF);
    endcase
  endfunction

  task automatic send_u(input logic [15:0] v);
    send_byte(CharBackslash);
    send_byte(CharLetterU);
    for (int i = 3; i >= 0; i--) send_byte(hex_char(v[i*4 +: 4]));
  endtask

  // One piece of string body. Mostly well-formed pieces so that held high
  // surrogates meet every kind of follow-up; the rest are broken escapes,
  // text ends and raw noise.
  task automatic send_segment();
    int unsigned pick;
    int unsigned k;
    int unsigned bad_at;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 30) begin
      b = 8'($urandom_range(255));
      if (b == CharQuote || b == CharBackslash) b = 8'h41;
      send_byte(b);
    end else if (pick < 37) begin
      send_byte(CharQuote);
    end else if (pick < 49) begin
      send_byte(CharBackslash);
      send_byte(simple_escape_letter());
    end else if (pick < 53) begin
      b = 8'($urandom_range(255));
      if (is_escape_letter(b)) b = 8'h71;  // q
      send_byte(CharBackslash);
      send_byte(b);
    end else if (pick < 69) begin
      send_u(u_value());
    end else if (pick < 79) begin
      send_u(span('hD800, 'hDBFF));
      send_u(span('hDC00, 'hDFFF));
    end else if (pick < 84) begin
      // one slot is not a hex digit; error comes at the fourth slot
      bad_at = $urandom_range(3);
      send_byte(CharBackslash);
      send_byte(CharLetterU);
      for (int i = 0; i < 4; i++) begin
        if (i == bad_at) send_byte(non_hex());
        else send_byte(hex_char(4'($urandom_range(15))));
      end
    end else if (pick < 89) begin
      // escape cut off by the text end, slots may hold junk
      k = $urandom_range(4);
      send_byte(CharBackslash);
      if (k != 0) begin
        send_byte(CharLetterU);
        repeat (k - 1) begin
          if ($urandom_range(3) == 0) send_byte(8'($urandom_range(255)));
          else send_byte(hex_char(4'($urandom_range(15))));
        end
      end
      send_end();
    end else if (pick < 94) begin
      send_end();
    end else begin
      send_req(8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned target;
    target = sent + n;
    while (sent < target) send_segment();
  endtask

  initial begin : main
    tracker = new();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: byte extremes, unknown escape, a surrogate pair (four UTF-8
    // bytes), done, bad hex with a quote in a slot, text end in plain mode,
    // after a backslash, and in the hex slots after a bad digit.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("\\q");
    send_text("\\uD83D\\uDE00");
    send_text("\"");
    send_text("\\u\"0F0");
    send_end();
    send_text("\\");
    send_end();
    send_text("\\uG");
    send_end();
    settle();

    // Sender idles less than the receiver; long hold-off right at the start.
    send_idle_pct = 37;
    recv_idle_pct = 51;
    hold_asks++;
    run_random(ItemsPerPhase);
    settle();

    // Rates swapped, with a drain pause in the middle.
    send_idle_pct = 51;
    recv_idle_pct = 37;
    run_random(ItemsPerPhase / 2);
    settle();
    run_random(ItemsPerPhase / 2);
    settle();

    // Back-to-back on both sides, then a hold-off against a full-rate sender.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(ItemsPerPhase / 2);
    hold_asks++;
    run_random(ItemsPerPhase / 2);
    settle();

    if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/jsu_pkg.sv
src/jsu_front.sv
src/jsu_queue.sv
src/jsu_back.sv
src/json_string_unescape_utf8_unit.sv
tb/unescape_check_pkg.sv
tb/tb_top.sv
